// ===== design/rrts_pkg.sv =====
// shared types, sizes and codes for the round-robin thread scheduler
package rrts_pkg;

    localparam int MAX_THREADS = 8;
    localparam int MAX_SEMS    = 4;
    localparam int COUNT_W     = 16;
    localparam int SLOT_W      = 3;
    localparam int SEM_W       = 2;
    localparam int LINK_W      = SLOT_W + 1;
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int AMOUNT_W    = 16;
    localparam int ACTION_W    = 3;
    localparam int RC_W        = 3;

    localparam logic [LINK_W-1:0] SLOT_NONE = LINK_W'(MAX_THREADS);

    // thread status
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_SLEEP = 2'd2;
    localparam logic [1:0] ST_BLOCK = 2'd3;

    // actions
    localparam logic [ACTION_W-1:0] ACT_CREATE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_YIELD   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SLEEP   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DESTROY = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_INIT    = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_DOWN    = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UP      = 3'd7;

    // result codes
    localparam logic [RC_W-1:0] RC_OK         = 3'd0;
    localparam logic [RC_W-1:0] RC_ALONE      = 3'd1;
    localparam logic [RC_W-1:0] RC_LOST       = 3'd2;
    localparam logic [RC_W-1:0] RC_NONE_READY = 3'd3;
    localparam logic [RC_W-1:0] RC_BAD        = 3'd4;

    // datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE          = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD          = 5'd1;
    localparam logic [OP_W-1:0] OP_RC_BAD        = 5'd2;
    localparam logic [OP_W-1:0] OP_CREATE_START  = 5'd3;
    localparam logic [OP_W-1:0] OP_CWALK_STEP    = 5'd4;
    localparam logic [OP_W-1:0] OP_CREATE_LINK   = 5'd5;
    localparam logic [OP_W-1:0] OP_SLEEP_SET     = 5'd6;
    localparam logic [OP_W-1:0] OP_TICK          = 5'd7;
    localparam logic [OP_W-1:0] OP_DESTROY_RELINK = 5'd8;
    localparam logic [OP_W-1:0] OP_SEM_INIT      = 5'd9;
    localparam logic [OP_W-1:0] OP_SEM_DEC       = 5'd10;
    localparam logic [OP_W-1:0] OP_DOWN_HEAD     = 5'd11;
    localparam logic [OP_W-1:0] OP_DOWN_START    = 5'd12;
    localparam logic [OP_W-1:0] OP_DWALK_STEP    = 5'd13;
    localparam logic [OP_W-1:0] OP_DOWN_TAIL     = 5'd14;
    localparam logic [OP_W-1:0] OP_RC_LOST       = 5'd15;
    localparam logic [OP_W-1:0] OP_UP_WAKE       = 5'd16;
    localparam logic [OP_W-1:0] OP_UP_COUNT      = 5'd17;
    localparam logic [OP_W-1:0] OP_YIELD_ALONE   = 5'd18;
    localparam logic [OP_W-1:0] OP_YIELD_START   = 5'd19;
    localparam logic [OP_W-1:0] OP_YWALK_STEP    = 5'd20;
    localparam logic [OP_W-1:0] OP_YIELD_TAKE    = 5'd21;
    localparam logic [OP_W-1:0] OP_RC_NONE       = 5'd22;
    localparam logic [OP_W-1:0] OP_UHEAD_TAKE    = 5'd23;
    localparam logic [OP_W-1:0] OP_UWALK_START   = 5'd24;
    localparam logic [OP_W-1:0] OP_UWALK_STEP    = 5'd25;
    localparam logic [OP_W-1:0] OP_UWALK_FIX     = 5'd26;
    localparam logic [OP_W-1:0] OP_NEXT_SEM      = 5'd27;
    localparam logic [OP_W-1:0] OP_FREE_SLOT     = 5'd28;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   thread_slot;
        logic [SEM_W-1:0]    sem_index;
        logic [AMOUNT_W-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [RC_W-1:0]   result_code;
        logic [SLOT_W-1:0] running_slot;
        logic              switched;
    } t_out_item;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic bad_create;
        logic bad_destroy;
        logic bad_sem;
        logic amount_nz;
        logic count_nz;
        logic cur_blocked;
        logic head_none;
        logic tgt_blocked;
        logic cwalk_stop;
        logic dwalk_stop;
        logic alone;
        logic ywalk_hit;
        logic ywalk_last;
        logic uhead_hit;
        logic uwalk_stop;
        logic uwalk_hit;
        logic k_last;
    } t_dp_status;

endpackage

// ===== design/round_robin_thread_scheduler.sv =====
// top level of the round-robin thread scheduler with counting semaphores
//
//   channel  | direction | payload     | handshake
//   ---------+-----------+-------------+---------------------------
//   in       | input     | t_in_item   | i_in_valid / o_in_stall
//   out      | output    | t_out_item  | o_out_valid / i_out_stall
//
// one item at a time, one result item per item; tick, sem init, up, a granted
// down and rejected items go from decode straight to the result; create walks
// the ring, yield and sleep walk it for a ready thread, a down that queues
// behind waiters walks the wait list first, destroy of a blocked slot walks them all
// reset puts slot 0 on the ring alone, ready and current
// the result register holds while stalled; the next item is taken meanwhile
module round_robin_thread_scheduler import rrts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // command and status between sequencer and datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer: decode, walk steps, result handshake
    rrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // datapath: ring, wait lists, semaphore counts, result register
    rrts_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_in_item),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_out_item (o_out_item)
    );

endmodule

// ===== design/rrts_dp.sv =====
// scheduler datapath: thread ring, wait lists, semaphores and walk pointer
module rrts_dp import rrts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_out_item
);

    logic [SLOT_W-1:0]  r_next  [MAX_THREADS];
    logic [1:0]         r_state [MAX_THREADS];
    logic [COUNT_W-1:0] r_sleep [MAX_THREADS];
    logic [LINK_W-1:0]  r_link  [MAX_THREADS];
    logic [COUNT_W-1:0] r_count [MAX_SEMS];
    logic [LINK_W-1:0]  r_head  [MAX_SEMS];
    logic [SLOT_W-1:0]  r_cur;

    t_in_item           r_item;
    t_out_item          r_out;
    logic [RC_W-1:0]    r_rc;
    logic [SLOT_W-1:0]  r_old;
    logic [LINK_W-1:0]  r_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [SEM_W-1:0]   r_sem_k;

    logic [SLOT_W-1:0]  slot;
    logic [SEM_W-1:0]   sem;
    logic [SLOT_W-1:0]  pi;
    logic [SLOT_W-1:0]  head_i;
    logic               pred_found;
    logic [SLOT_W-1:0]  pred_idx;

    assign slot   = r_item.thread_slot;
    assign sem    = r_item.sem_index;
    assign pi     = r_ptr[SLOT_W-1:0];
    assign head_i = r_head[sem][SLOT_W-1:0];

    // ring predecessor of the slot being destroyed, lowest index first
    always_comb begin
        pred_found = 1'b0;
        pred_idx   = '0;
        for (int i = MAX_THREADS - 1; i >= 0; i--) begin
            if (SLOT_W'(i) != slot && r_state[i] != ST_FREE && r_next[i] == slot) begin
                pred_found = 1'b1;
                pred_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        o_status.action      = r_item.action;
        o_status.bad_create  = r_state[slot] != ST_FREE;
        o_status.bad_destroy = slot == '0 || slot == r_cur || r_state[slot] == ST_FREE;
        o_status.bad_sem     = {1'b0, sem} >= (SEM_W + 1)'(MAX_SEMS);
        o_status.amount_nz   = r_item.amount != '0;
        o_status.count_nz    = r_count[sem] != '0;
        o_status.cur_blocked = r_state[r_cur] == ST_BLOCK;
        o_status.head_none   = r_head[sem] >= SLOT_NONE;
        o_status.tgt_blocked = r_state[slot] == ST_BLOCK;
        o_status.cwalk_stop  = r_cnt == CNT_W'(MAX_THREADS) || r_next[pi] == r_cur;
        o_status.dwalk_stop  = r_cnt == CNT_W'(MAX_THREADS) || r_link[pi] >= SLOT_NONE;
        o_status.alone       = r_next[r_cur] == r_cur;
        o_status.ywalk_hit   = r_state[r_next[pi]] == ST_READY;
        o_status.ywalk_last  = r_cnt == CNT_W'(MAX_THREADS - 1);
        o_status.uhead_hit   = r_head[r_sem_k] == {1'b0, slot};
        o_status.uwalk_stop  = r_cnt == CNT_W'(MAX_THREADS) || r_ptr >= SLOT_NONE;
        o_status.uwalk_hit   = r_link[pi] == {1'b0, slot};
        o_status.k_last      = r_sem_k == SEM_W'(MAX_SEMS - 1);
    end

    // scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_next[i]  <= SLOT_W'(i);
                r_state[i] <= (i == 0) ? ST_READY : ST_FREE;
                r_sleep[i] <= '0;
                r_link[i]  <= SLOT_NONE;
            end
            for (int k = 0; k < MAX_SEMS; k++) begin
                r_count[k] <= '0;
                r_head[k]  <= SLOT_NONE;
            end
            r_cur <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_CREATE_LINK: begin
                    r_state[slot] <= ST_READY;
                    r_sleep[slot] <= '0;
                    r_link[slot]  <= SLOT_NONE;
                    r_next[slot]  <= r_cur;
                    r_next[pi]    <= slot;
                end
                OP_SLEEP_SET: begin
                    r_state[r_cur] <= ST_SLEEP;
                    r_sleep[r_cur] <= COUNT_W'(r_item.amount);
                end
                OP_TICK: begin
                    for (int i = 0; i < MAX_THREADS; i++) begin
                        if (r_state[i] == ST_SLEEP) begin
                            if (r_sleep[i] <= COUNT_W'(1)) begin
                                r_sleep[i] <= '0;
                                r_state[i] <= ST_READY;
                            end else begin
                                r_sleep[i] <= r_sleep[i] - COUNT_W'(1);
                            end
                        end
                    end
                end
                OP_DESTROY_RELINK: begin
                    if (pred_found) begin
                        r_next[pred_idx] <= r_next[slot];
                    end
                end
                OP_SEM_INIT: begin
                    r_count[sem] <= COUNT_W'(r_item.amount);
                    r_head[sem]  <= SLOT_NONE;
                end
                OP_SEM_DEC: begin
                    r_count[sem] <= r_count[sem] - COUNT_W'(1);
                end
                OP_DOWN_HEAD: begin
                    r_link[r_cur]  <= SLOT_NONE;
                    r_head[sem]    <= {1'b0, r_cur};
                    r_state[r_cur] <= ST_BLOCK;
                    r_sleep[r_cur] <= '0;
                end
                OP_DOWN_START: begin
                    r_link[r_cur] <= SLOT_NONE;
                end
                OP_DOWN_TAIL: begin
                    r_link[pi]     <= {1'b0, r_cur};
                    r_state[r_cur] <= ST_BLOCK;
                    r_sleep[r_cur] <= '0;
                end
                OP_UP_WAKE: begin
                    r_head[sem]     <= r_link[head_i];
                    r_link[head_i]  <= SLOT_NONE;
                    r_state[head_i] <= ST_READY;
                end
                OP_UP_COUNT: begin
                    r_count[sem] <= COUNT_W'(1);
                end
                OP_YIELD_TAKE: begin
                    r_cur <= r_next[pi];
                end
                OP_UHEAD_TAKE: begin
                    r_head[r_sem_k] <= r_link[slot];
                end
                OP_UWALK_FIX: begin
                    r_link[pi] <= r_link[slot];
                end
                OP_FREE_SLOT: begin
                    r_state[slot] <= ST_FREE;
                    r_next[slot]  <= slot;
                    r_sleep[slot] <= '0;
                    r_link[slot]  <= SLOT_NONE;
                end
                default: begin
                end
            endcase
        end
    end

    // item, walk pointer, counters and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.result_code  <= r_rc;
            r_out.running_slot <= r_cur;
            r_out.switched     <= r_cur != r_old;
        end
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_item <= i_item;
                r_rc   <= RC_OK;
                r_old  <= r_cur;
            end
            OP_RC_BAD:      r_rc <= RC_BAD;
            OP_RC_LOST:     r_rc <= RC_LOST;
            OP_RC_NONE:     r_rc <= RC_NONE_READY;
            OP_YIELD_ALONE: r_rc <= RC_ALONE;
            OP_CREATE_START, OP_YIELD_START: begin
                r_ptr <= {1'b0, r_cur};
                r_cnt <= '0;
            end
            OP_CWALK_STEP, OP_YWALK_STEP: begin
                r_ptr <= {1'b0, r_next[pi]};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            OP_DOWN_START: begin
                r_ptr <= r_head[sem];
                r_cnt <= '0;
            end
            OP_DWALK_STEP, OP_UWALK_STEP: begin
                r_ptr <= r_link[pi];
                r_cnt <= r_cnt + CNT_W'(1);
            end
            OP_DESTROY_RELINK: r_sem_k <= '0;
            OP_UWALK_START: begin
                r_ptr <= r_head[r_sem_k];
                r_cnt <= '0;
            end
            OP_UHEAD_TAKE, OP_UWALK_FIX, OP_NEXT_SEM: begin
                r_sem_k <= r_sem_k + SEM_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_out_item = r_out;

endmodule

// ===== design/rrts_ctrl.sv =====
// scheduler sequencer: decodes each item and steps the datapath walks
module rrts_ctrl import rrts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_CWALK  = 4'd2;
    localparam logic [3:0] S_DWALK  = 4'd3;
    localparam logic [3:0] S_YSTART = 4'd4;
    localparam logic [3:0] S_YWALK  = 4'd5;
    localparam logic [3:0] S_UHEAD  = 4'd6;
    localparam logic [3:0] S_UWALK  = 4'd7;
    localparam logic [3:0] S_FREE   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0] r_fsm, n_fsm;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_fsm != S_IDLE;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_fsm        = r_fsm;
        o_cmd.op     = OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_fsm)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_fsm    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_fsm = S_DONE;
                unique case (i_status.action)
                    ACT_CREATE: begin
                        if (i_status.bad_create) begin
                            o_cmd.op = OP_RC_BAD;
                        end else begin
                            o_cmd.op = OP_CREATE_START;
                            n_fsm    = S_CWALK;
                        end
                    end
                    ACT_YIELD: n_fsm = S_YSTART;
                    ACT_SLEEP: begin
                        if (i_status.amount_nz) o_cmd.op = OP_SLEEP_SET;
                        n_fsm = S_YSTART;
                    end
                    ACT_TICK: o_cmd.op = OP_TICK;
                    ACT_DESTROY: begin
                        if (i_status.bad_destroy) begin
                            o_cmd.op = OP_RC_BAD;
                        end else begin
                            o_cmd.op = OP_DESTROY_RELINK;
                            n_fsm    = i_status.tgt_blocked ? S_UHEAD : S_FREE;
                        end
                    end
                    ACT_INIT: o_cmd.op = i_status.bad_sem ? OP_RC_BAD : OP_SEM_INIT;
                    ACT_DOWN: begin
                        if (i_status.bad_sem) begin
                            o_cmd.op = OP_RC_BAD;
                        end else if (i_status.count_nz) begin
                            o_cmd.op = OP_SEM_DEC;
                        end else if (i_status.cur_blocked) begin
                            n_fsm = S_YSTART;
                        end else if (i_status.head_none) begin
                            o_cmd.op = OP_DOWN_HEAD;
                            n_fsm    = S_YSTART;
                        end else begin
                            o_cmd.op = OP_DOWN_START;
                            n_fsm    = S_DWALK;
                        end
                    end
                    ACT_UP: begin
                        if (i_status.bad_sem)        o_cmd.op = OP_RC_BAD;
                        else if (i_status.count_nz)  o_cmd.op = OP_RC_LOST;
                        else if (i_status.head_none) o_cmd.op = OP_UP_COUNT;
                        else                         o_cmd.op = OP_UP_WAKE;
                    end
                    default: n_fsm = S_DONE;
                endcase
            end
            S_CWALK: begin
                if (i_status.cwalk_stop) begin
                    o_cmd.op = OP_CREATE_LINK;
                    n_fsm    = S_DONE;
                end else begin
                    o_cmd.op = OP_CWALK_STEP;
                end
            end
            S_DWALK: begin
                if (i_status.dwalk_stop) begin
                    o_cmd.op = OP_DOWN_TAIL;
                    n_fsm    = S_YSTART;
                end else begin
                    o_cmd.op = OP_DWALK_STEP;
                end
            end
            S_YSTART: begin
                if (i_status.alone) begin
                    o_cmd.op = OP_YIELD_ALONE;
                    n_fsm    = S_DONE;
                end else begin
                    o_cmd.op = OP_YIELD_START;
                    n_fsm    = S_YWALK;
                end
            end
            S_YWALK: begin
                if (i_status.ywalk_hit) begin
                    o_cmd.op = OP_YIELD_TAKE;
                    n_fsm    = S_DONE;
                end else if (i_status.ywalk_last) begin
                    o_cmd.op = OP_RC_NONE;
                    n_fsm    = S_DONE;
                end else begin
                    o_cmd.op = OP_YWALK_STEP;
                end
            end
            S_UHEAD: begin
                if (i_status.uhead_hit) begin
                    o_cmd.op = OP_UHEAD_TAKE;
                    if (i_status.k_last) n_fsm = S_FREE;
                end else begin
                    o_cmd.op = OP_UWALK_START;
                    n_fsm    = S_UWALK;
                end
            end
            S_UWALK: begin
                if (i_status.uwalk_stop || i_status.uwalk_hit) begin
                    o_cmd.op = i_status.uwalk_stop ? OP_NEXT_SEM : OP_UWALK_FIX;
                    n_fsm    = i_status.k_last ? S_FREE : S_UHEAD;
                end else begin
                    o_cmd.op = OP_UWALK_STEP;
                end
            end
            S_FREE: begin
                o_cmd.op = OP_FREE_SLOT;
                n_fsm    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_fsm          = S_IDLE;
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load)    n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/rrts_checker.sv =====
// port-level checks for the thread scheduler and their bind
module rrts_port_checks import rrts_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    // an accepted item keeps the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while previous one in flight");

    // a thread switch only comes with an ok result
    a_switch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.switched |-> o_out_item.result_code == RC_OK)
        else $error("switch reported with an error code");

    // result codes stay in their range
    a_rc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.result_code == RC_OK ||
            o_out_item.result_code == RC_ALONE || o_out_item.result_code == RC_LOST ||
            o_out_item.result_code == RC_NONE_READY || o_out_item.result_code == RC_BAD)
        else $error("result code out of range");

endmodule

bind round_robin_thread_scheduler rrts_port_checks u_rrts_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ===== sim/rrts_checker.sv =====
// checker for the thread scheduler: watches both channels, predicts and compares
module rrts_checker import rrts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    logic [SLOT_W-1:0]  nxt [MAX_THREADS];
    logic [1:0]         status [MAX_THREADS];
    logic [COUNT_W-1:0] nap [MAX_THREADS];
    logic [LINK_W-1:0]  wlink [MAX_THREADS];
    logic [COUNT_W-1:0] scount [MAX_SEMS];
    logic [LINK_W-1:0]  shead [MAX_SEMS];
    logic [SLOT_W-1:0]  cur;
    t_out_item          sched_q [$];

    function automatic logic [RC_W-1:0] pick_next();
        logic [SLOT_W-1:0] p;
        p = cur;
        if (nxt[p] == p) return RC_ALONE;
        for (int n = 0; n < MAX_THREADS; n++) begin
            p = nxt[p];
            if (status[p] == ST_READY) begin
                cur = p;
                return RC_OK;
            end
        end
        return RC_NONE_READY;
    endfunction

    function automatic void drop_waiter(int s);
        int p;
        for (int k = 0; k < MAX_SEMS; k++) begin
            if (shead[k] == s) begin
                shead[k] = wlink[s];
                continue;
            end
            p = int'(shead[k]);
            for (int n = 0; n < MAX_THREADS && p < MAX_THREADS; n++) begin
                if (wlink[p] == s) begin
                    wlink[p] = wlink[s];
                    break;
                end
                p = int'(wlink[p]);
            end
        end
        wlink[s] = SLOT_NONE;
    endfunction

    function automatic t_out_item schedule(t_in_item it);
        t_out_item r;
        logic [SLOT_W-1:0] old, s, p;
        logic [RC_W-1:0] rc;
        int q;
        old = cur;
        s = it.thread_slot;
        rc = RC_OK;
        case (it.action)
            ACT_CREATE: begin
                if (status[s] != ST_FREE) rc = RC_BAD;
                else begin
                    p = cur;
                    for (int n = 0; n < MAX_THREADS && nxt[p] != cur; n++) p = nxt[p];
                    status[s] = ST_READY;
                    nap[s] = '0;
                    wlink[s] = SLOT_NONE;
                    nxt[s] = cur;
                    nxt[p] = s;
                end
            end
            ACT_YIELD: rc = pick_next();
            ACT_SLEEP: begin
                if (it.amount != 0) begin
                    status[cur] = ST_SLEEP;
                    nap[cur] = it.amount;
                end
                rc = pick_next();
            end
            ACT_TICK: begin
                for (int i = 0; i < MAX_THREADS; i++)
                    if (status[i] == ST_SLEEP) begin
                        if (nap[i] <= 1) begin
                            nap[i] = '0;
                            status[i] = ST_READY;
                        end else nap[i]--;
                    end
            end
            ACT_DESTROY: begin
                if (s == 0 || s == cur || status[s] == ST_FREE) rc = RC_BAD;
                else begin
                    for (int i = 0; i < MAX_THREADS; i++)
                        if (i != s && status[i] != ST_FREE && nxt[i] == s) begin
                            nxt[i] = nxt[s];
                            break;
                        end
                    if (status[s] == ST_BLOCK) drop_waiter(int'(s));
                    status[s] = ST_FREE;
                    nxt[s] = s;
                    nap[s] = '0;
                    wlink[s] = SLOT_NONE;
                end
            end
            ACT_INIT: begin
                scount[it.sem_index] = it.amount;
                shead[it.sem_index] = SLOT_NONE;
            end
            ACT_DOWN: begin
                if (scount[it.sem_index] != 0) scount[it.sem_index]--;
                else begin
                    if (status[cur] != ST_BLOCK) begin
                        wlink[cur] = SLOT_NONE;
                        if (shead[it.sem_index] >= MAX_THREADS) begin
                            shead[it.sem_index] = {1'b0, cur};
                        end else begin
                            q = int'(shead[it.sem_index]);
                            for (int n = 0; n < MAX_THREADS && wlink[q] < MAX_THREADS; n++)
                                q = int'(wlink[q]);
                            wlink[q] = {1'b0, cur};
                        end
                        status[cur] = ST_BLOCK;
                        nap[cur] = '0;
                    end
                    rc = pick_next();
                end
            end
            default: begin
                if (scount[it.sem_index] != 0) rc = RC_LOST;
                else if (shead[it.sem_index] < MAX_THREADS) begin
                    q = int'(shead[it.sem_index]);
                    shead[it.sem_index] = wlink[q];
                    wlink[q] = SLOT_NONE;
                    status[q] = ST_READY;
                end else scount[it.sem_index] = COUNT_W'(1);
            end
        endcase
        r.result_code = rc;
        r.running_slot = cur;
        r.switched = (cur != old);
        return r;
    endfunction

    assign o_pending = sched_q.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_THREADS; i++) begin
                nxt[i] <= SLOT_W'(i);
                status[i] <= (i == 0) ? ST_READY : ST_FREE;
                nap[i] <= '0;
                wlink[i] <= SLOT_NONE;
            end
            for (int i = 0; i < MAX_SEMS; i++) begin
                scount[i] <= '0;
                shead[i] <= SLOT_NONE;
            end
            cur <= '0;
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sched_q.size() == 0) begin
                    $display("%0t: unexpected item %p", $time, i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = sched_q.pop_front();
                    if (want !== i_out_item) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, i_out_item);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // prediction updates the model state in place
            if (i_in_valid && !i_in_stall) sched_q.push_back(schedule(i_in_item));
        end
    end

endmodule

// ===== sim/round_robin_thread_scheduler_test.sv =====
// testbench top: stimulus, idling and verdict for the thread scheduler
module round_robin_thread_scheduler_test import rrts_pkg::*;;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    bit        hold_long = 1'b0;   // long receiver hold-off request

    always #4 clk = ~clk;

    round_robin_thread_scheduler i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item)
    );

    rrts_checker u_check (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // random item, weighted so that threads exist and semaphores get exercised
    function automatic t_in_item rand_item();
        t_in_item it;
        int w;
        it.thread_slot = SLOT_W'($urandom_range(0, 7));
        it.sem_index = SEM_W'($urandom_range(0, 3));
        w = $urandom_range(0, 9);
        if (w < 2) it.amount = AMOUNT_W'($urandom);        // full 16-bit spread
        else it.amount = AMOUNT_W'($urandom_range(0, 4)); // short sleeps, small counts
        w = $urandom_range(0, 15);
        case (w)
            0, 1, 2:  it.action = ACT_CREATE;
            3, 4:     it.action = ACT_YIELD;
            5, 6:     it.action = ACT_SLEEP;
            7, 8, 9:  it.action = ACT_TICK;
            10:       it.action = ACT_DESTROY;
            11:       it.action = ACT_INIT;
            12, 13:   it.action = ACT_DOWN;
            default:  it.action = ACT_UP;
        endcase
        return it;
    endfunction

    function automatic t_in_item mk(logic [ACTION_W-1:0] a, int s, int m, int amt);
        t_in_item it;
        it.action = a;
        it.thread_slot = SLOT_W'(s);
        it.sem_index = SEM_W'(m);
        it.amount = AMOUNT_W'(amt);
        return it;
    endfunction

    // offer one item and hold it until accepted
    task automatic send(t_in_item it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // receiver stall: random per item, plus one long hold-off
    initial begin
        int w;
        @(posedge clk);
        forever begin
            if (hold_long) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_long = 1'b0;
            end
            w = $urandom_range(0, 7);
            if (w != 0 && $urandom_range(0, 1)) begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        t_in_item dir [$];
        int waited;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: lone thread, bad slots, semaphores, maximum sleep
        dir.push_back(mk(ACT_YIELD, 0, 0, 0));
        dir.push_back(mk(ACT_SLEEP, 0, 0, 0));
        dir.push_back(mk(ACT_DESTROY, 0, 0, 0));
        dir.push_back(mk(ACT_CREATE, 0, 0, 0));
        dir.push_back(mk(ACT_DESTROY, 5, 0, 0));
        dir.push_back(mk(ACT_CREATE, 7, 3, 16'hffff));
        dir.push_back(mk(ACT_CREATE, 1, 0, 0));
        dir.push_back(mk(ACT_YIELD, 0, 0, 0));
        dir.push_back(mk(ACT_DESTROY, 1, 0, 0));
        dir.push_back(mk(ACT_SLEEP, 0, 0, 16'hffff));
        dir.push_back(mk(ACT_UP, 0, 2, 0));
        dir.push_back(mk(ACT_UP, 0, 2, 0));
        dir.push_back(mk(ACT_DOWN, 0, 1, 0));
        dir.push_back(mk(ACT_DOWN, 0, 1, 0));
        dir.push_back(mk(ACT_SLEEP, 0, 0, 1));
        dir.push_back(mk(ACT_TICK, 0, 0, 0));
        dir.push_back(mk(ACT_UP, 0, 1, 0));
        dir.push_back(mk(ACT_INIT, 0, 3, 16'hffff));
        dir.push_back(mk(ACT_DOWN, 0, 3, 0));
        dir.push_back(mk(ACT_DOWN, 0, 0, 0));
        dir.push_back(mk(ACT_INIT, 0, 0, 0));
        dir.push_back(mk(ACT_DESTROY, 7, 0, 0));
        dir.push_back(mk(ACT_DESTROY, 1, 0, 0));
        foreach (dir[i]) send(dir[i]);
        for (int n = 0; n < 400; n++) begin
            if (n == 150) hold_long = 1'b1;  // block backs up while we keep offering
            send(rand_item());
        end
        in_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
